FILE: src/swfd_pkg.sv
// Package for the sync-word frame deframer.
// Holds the header position codes, sync word, state and result types.
// No dependencies.
package swfd_pkg;

	localparam int unsigned SYNC_LEN = 4;

	typedef enum logic [2:0] {
		POS_SYNC0   = 3'd0,
		POS_SYNC1   = 3'd1,
		POS_SYNC2   = 3'd2,
		POS_SYNC3   = 3'd3,
		POS_LEN_LO  = 3'd4,
		POS_LEN_HI  = 3'd5,
		POS_CHECK   = 3'd6,
		POS_PAYLOAD = 3'd7
	} hdr_pos_t;

	// "UART", first byte expected first
	localparam logic [7:0] SYNC_WORD [SYNC_LEN] = '{8'h55, 8'h41, 8'h52, 8'h54};

	localparam logic [15:0] MAX_LEN_RESET = 16'd255;

	typedef struct packed {
		hdr_pos_t    pos;
		logic [15:0] len;
		logic [7:0]  chk;
		logic [15:0] cnt;
	} dfr_state_t;

	typedef struct packed {
		logic [7:0]  payload_byte;
		logic [15:0] payload_offset;
		logic        data_valid;
		logic        frame_last;
		logic [15:0] declared_length;
		logic [7:0]  header_check;
	} dfr_result_t;

endpackage

FILE: src/sync_word_frame_deframer_core.sv
// Top level of the sync-word frame deframer.
// Uses swfd_pkg and swfd_step.
//
// The block takes one received byte per transfer and hunts for the sync word
// "UART", then reads a little-endian 16-bit length and a check byte, and
// passes on min(length, max_payload_length) payload bytes, each with its
// offset; the final one carries frame_last. A frame whose kept length is zero
// gives one result with data_valid low and frame_last high. The check byte is
// reported, never verified. A byte can be taken on every clock cycle unless a
// result waits on a stalled result channel; its result, if it has one, passes
// from the byte register through the combinational header/payload update
// into the result register. Write max_payload_length (reset 255) only while
// the block is idle.
module sync_word_frame_deframer_core (
	input  logic        clk,
	input  logic        arst_n,
	// byte channel
	input  logic [7:0]  rx_byte,
	input  logic        rx_valid,
	output logic        rx_stall,
	// result channel
	output logic [7:0]  payload_byte,
	output logic [15:0] payload_offset,
	output logic        data_valid,
	output logic        frame_last,
	output logic [15:0] declared_length,
	output logic [7:0]  header_check,
	output logic        res_valid,
	input  logic        res_stall,
	// configuration
	input  logic        cfg_we,
	input  logic [15:0] cfg_data
);

	logic [15:0]           max_len_q;
	logic                  valid_s1;
	logic [7:0]            byte_s1;
	swfd_pkg::dfr_state_t  state_q;
	swfd_pkg::dfr_state_t  state_nxt;
	logic                  has_result;
	swfd_pkg::dfr_result_t result;
	swfd_pkg::dfr_result_t res_q;
	logic                  res_valid_q;
	logic                  out_free;
	logic                  consume_s1;
	logic                  load_s1;

	// result register can take a new item when empty or being drained
	assign out_free   = !res_valid_q || !res_stall;
	// a byte without a result never waits on the output side
	assign consume_s1 = valid_s1 && (!has_result || out_free);
	assign rx_stall   = valid_s1 && !consume_s1;
	assign load_s1    = rx_valid && !rx_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= swfd_pkg::MAX_LEN_RESET;
		end else if (cfg_we) begin
			max_len_q <= cfg_data;
		end
	end

	// byte register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1 || consume_s1) begin
			valid_s1 <= load_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			byte_s1 <= rx_byte;
		end
	end

	swfd_step u_step (
		.cur        (state_q),
		.rx_byte    (byte_s1),
		.max_len    (max_len_q),
		.nxt        (state_nxt),
		.has_result (has_result),
		.result     (result)
	);

	// header state: advance once per consumed byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{pos: swfd_pkg::POS_SYNC0, len: '0, chk: '0, cnt: '0};
		end else if (consume_s1) begin
			state_q <= state_nxt;
		end
	end

	// result register: hold while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_free) begin
			res_valid_q <= consume_s1 && has_result;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && consume_s1 && has_result) begin
			res_q <= result;
		end
	end

	assign res_valid       = res_valid_q;
	assign payload_byte    = res_q.payload_byte;
	assign payload_offset  = res_q.payload_offset;
	assign data_valid      = res_q.data_valid;
	assign frame_last      = res_q.frame_last;
	assign declared_length = res_q.declared_length;
	assign header_check    = res_q.header_check;

endmodule

FILE: src/swfd_step.sv
// One byte step of the deframer: next header state and the optional result.
// Purely combinational; uses swfd_pkg.
module swfd_step (
	input  swfd_pkg::dfr_state_t  cur,
	input  logic [7:0]            rx_byte,
	input  logic [15:0]           max_len,
	output swfd_pkg::dfr_state_t  nxt,
	output logic                  has_result,
	output swfd_pkg::dfr_result_t result
);

	logic [15:0] len_full;
	logic [15:0] kept;
	logic [16:0] cnt_inc;
	logic        pay_last;

	// length as it stands once the high byte is in
	assign len_full = cur.len;
	assign kept     = (len_full < max_len) ? len_full : max_len;
	assign cnt_inc  = {1'b0, cur.cnt} + 17'd1;
	assign pay_last = cnt_inc >= {1'b0, kept};

	always_comb begin
		nxt        = cur;
		has_result = 1'b0;
		result     = '0;
		result.declared_length = cur.len;
		result.header_check    = cur.chk;
		unique case (cur.pos)
			swfd_pkg::POS_SYNC0, swfd_pkg::POS_SYNC1,
			swfd_pkg::POS_SYNC2, swfd_pkg::POS_SYNC3: begin
				// drop a mismatching byte and restart the hunt
				if (rx_byte == swfd_pkg::SYNC_WORD[cur.pos[1:0]])
					nxt.pos = swfd_pkg::hdr_pos_t'(cur.pos + 3'd1);
				else
					nxt.pos = swfd_pkg::POS_SYNC0;
			end
			swfd_pkg::POS_LEN_LO: begin
				nxt.len = {8'h00, rx_byte};
				nxt.pos = swfd_pkg::POS_LEN_HI;
			end
			swfd_pkg::POS_LEN_HI: begin
				nxt.len = {rx_byte, cur.len[7:0]};
				nxt.pos = swfd_pkg::POS_CHECK;
			end
			swfd_pkg::POS_CHECK: begin
				nxt.chk = rx_byte;
				nxt.cnt = '0;
				result.header_check = rx_byte;
				if (kept == 16'd0) begin
					has_result        = 1'b1;
					result.frame_last = 1'b1;
					nxt.pos           = swfd_pkg::POS_SYNC0;
				end else begin
					nxt.pos = swfd_pkg::POS_PAYLOAD;
				end
			end
			swfd_pkg::POS_PAYLOAD: begin
				has_result            = 1'b1;
				result.payload_byte   = rx_byte;
				result.payload_offset = cur.cnt;
				result.data_valid     = 1'b1;
				result.frame_last     = pay_last;
				if (pay_last) begin
					nxt.pos = swfd_pkg::POS_SYNC0;
					nxt.cnt = '0;
				end else begin
					nxt.cnt = cnt_inc[15:0];
				end
			end
			default: begin
				nxt.pos = swfd_pkg::POS_SYNC0;
			end
		endcase
	end

endmodule

FILE: src/swfd_checker.sv
// Port-level checker for the sync-word frame deframer, bound to the top level.
// Depends only on the top level's ports.
module swfd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        rx_stall,
	input logic [7:0]  payload_byte,
	input logic [15:0] payload_offset,
	input logic        data_valid,
	input logic        frame_last,
	input logic [15:0] declared_length,
	input logic        res_valid,
	input logic        res_stall
);

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(payload_byte)
			&& $stable(payload_offset) && $stable(frame_last))
		else $error("stalled result changed");

	// an empty frame is a single zeroed last result
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !data_valid |-> frame_last && payload_byte == 8'd0
			&& payload_offset == 16'd0)
		else $error("malformed empty-frame result");

	// payload offset stays inside the declared length
	a_offset: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && data_valid |-> payload_offset < declared_length)
		else $error("payload offset beyond declared length");

	// input only backs up when the output is blocked
	a_backup: assert property (@(posedge clk) disable iff (!arst_n)
		rx_stall |-> res_valid && res_stall)
		else $error("input stalled while output free");

endmodule

bind sync_word_frame_deframer_core swfd_checker u_swfd_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.rx_stall        (rx_stall),
	.payload_byte    (payload_byte),
	.payload_offset  (payload_offset),
	.data_valid      (data_valid),
	.frame_last      (frame_last),
	.declared_length (declared_length),
	.res_valid       (res_valid),
	.res_stall       (res_stall)
);
